@@ src/assert_macros.svh @@
// assertion macros shared by the top level and the transfer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) `ASSERT_PROP(lbl, !(cond))
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ src/spim_pkg.sv @@
// shared types and constants of the spi master
`default_nettype none
package spim_pkg;

  localparam int SelectLines = 32;
  localparam int DividerBits = 16;
  localparam int PaddrWidth  = 4;
  localparam logic [DividerBits-1:0] DivisorReset = DividerBits'(124);

  typedef enum logic [1:0] {
    REG_DIVISOR  = 2'd0,
    REG_POLARITY = 2'd1,
    REG_PHASE    = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_START  = 2'd2,
    CMD_MODE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DELAY  = 2'd1,
    PH_FIRST  = 2'd2,
    PH_SECOND = 2'd3
  } phase_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  tx_byte;
    logic [31:0] select_word;
    logic [4:0]  mode_bits;
    logic        miso;
  } in_t;

  typedef struct packed {
    logic        sclk;
    logic        mosi;
    logic [31:0] select_n;
    logic [7:0]  rx_byte;
    logic        ready_res;
    logic [4:0]  mode_out;
  } out_t;

  typedef struct packed {
    logic [DividerBits-1:0] divisor;
    logic                   cpol;
    logic                   cpha;
  } cfg_t;

endpackage
`default_nettype wire

@@ src/spi_master_with_select_register_unit.sv @@
// top level of the spi master with select and display-control registers
//
// each input item is one tick of the spi master: a command (tick only,
// write select lines, start a transfer, write mode bits), the byte to send,
// the select word, the mode bits and the miso level. every item gives
// exactly one result item: sclk, mosi, select lines, last received byte,
// ready and mode bits, as they stand after that tick.
// the input item is registered, the tick is evaluated by the transfer
// state machine and the result is registered, so a result is offered
// from the result register once its item has passed the input register.
// one item is taken every cycle while the input channel does not stall.
// when the receiver stalls, the result register holds its item and the
// input register fills; the input channel stalls only while both are full.
// clock divisor, polarity and phase are written over the apb port; the user
// must see them changed only while no item is in flight (block: not enforced).
// reset empties both registers, puts the machine in idle, clears the
// shifters and mode bits, sets all select lines high (inactive) and
// loads a divisor of 124 with mode 0.
`default_nettype none
`include "assert_macros.svh"
module spi_master_with_select_register_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  spim_pkg::in_t                   in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output spim_pkg::out_t                  out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spim_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  spim_pkg::cfg_t cfg;
  spim_pkg::in_t  in_item_q;
  spim_pkg::out_t out_item_q, result;
  logic           in_valid_q;
  logic           out_valid_q;
  logic           out_busy;
  logic           advance;
  logic           accept;

  spim_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  spim_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .item_i  (in_item_q),
    .cfg_i   (cfg),
    .result_o(result)
  );

  assign out_busy    = out_valid_q & out_stall_i;
  assign advance     = in_valid_q & ~out_busy;
  assign in_stall_o  = in_valid_q & out_busy;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  `ASSERT_NEVER(a_stall_needs_full, in_stall_o && !(in_valid_q && out_valid_q))
  `ASSERT_PROP(a_advance_fills_out, advance |=> out_valid_q)
  `ASSERT_PROP(a_drain_empties, out_valid_q && !out_stall_i && !in_valid_q |=> !out_valid_q)

endmodule
`default_nettype wire

@@ src/spim_regs.sv @@
// apb configuration registers: divisor, polarity, phase
`default_nettype none
module spim_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spim_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output spim_pkg::cfg_t                  cfg_o
);

  spim_pkg::cfg_t     cfg_q, cfg_d;
  spim_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = spim_pkg::reg_idx_e'(paddr[spim_pkg::PaddrWidth-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        spim_pkg::REG_DIVISOR:  cfg_d.divisor = spim_pkg::DividerBits'(pwdata[15:0]);
        spim_pkg::REG_POLARITY: cfg_d.cpol = pwdata[0];
        spim_pkg::REG_PHASE:    cfg_d.cpha = pwdata[0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      spim_pkg::REG_DIVISOR:  prdata = 32'(cfg_q.divisor);
      spim_pkg::REG_POLARITY: prdata = {31'd0, cfg_q.cpol};
      spim_pkg::REG_PHASE:    prdata = {31'd0, cfg_q.cpha};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.divisor <= spim_pkg::DivisorReset;
      cfg_q.cpol    <= 1'b0;
      cfg_q.cpha    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ src/spim_core.sv @@
// transfer state machine, shifters and select/mode registers
`default_nettype none
`include "assert_macros.svh"
module spim_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  spim_pkg::in_t  item_i,
  input  spim_pkg::cfg_t cfg_i,
  output spim_pkg::out_t result_o
);

  spim_pkg::phase_e                   phase_q, phase_d;
  logic [spim_pkg::DividerBits-1:0]   tick_q, tick_d, tick_step;
  logic [2:0]                         bit_q, bit_d;
  logic [7:0]                         tx_q, tx_d;
  logic [7:0]                         rx_q, rx_d;
  logic [7:0]                         hold_q, hold_d;
  logic [spim_pkg::SelectLines-1:0]   sel_q, sel_d;
  logic [4:0]                         mode_q, mode_d;
  logic                               sclk_q, sclk_d;
  logic                               half_done;
  logic                               pclk;

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    hold_d    = hold_q;
    sel_d     = sel_q;
    mode_d    = mode_q;
    half_done = (tick_q == cfg_i.divisor);
    tick_step = half_done ? '0 : tick_q + 1'b1;
    pclk      = (phase_q == spim_pkg::PH_SECOND && !cfg_i.cpha) ||
                (phase_q == spim_pkg::PH_FIRST && cfg_i.cpha);
    sclk_d    = pclk ^ cfg_i.cpol;

    case (phase_q)
      spim_pkg::PH_IDLE: begin
        if (item_i.cmd == spim_pkg::CMD_START) begin
          tx_d    = item_i.tx_byte;
          tick_d  = '0;
          bit_d   = 3'd0;
          phase_d = cfg_i.cpha ? spim_pkg::PH_DELAY : spim_pkg::PH_FIRST;
        end
      end
      spim_pkg::PH_DELAY: begin
        tick_d = tick_step;
        if (half_done) phase_d = spim_pkg::PH_FIRST;
      end
      spim_pkg::PH_FIRST: begin
        tick_d = tick_step;
        if (half_done) begin
          rx_d    = {rx_q[6:0], item_i.miso};
          phase_d = spim_pkg::PH_SECOND;
        end
      end
      spim_pkg::PH_SECOND: begin
        tick_d = tick_step;
        if (half_done) begin
          if (bit_q == 3'd7) begin
            hold_d  = rx_q;
            phase_d = spim_pkg::PH_IDLE;
          end else begin
            tx_d    = {tx_q[6:0], 1'b0};
            bit_d   = bit_q + 3'd1;
            phase_d = spim_pkg::PH_FIRST;
          end
        end
      end
      default: phase_d = spim_pkg::PH_IDLE;
    endcase

    if (item_i.cmd == spim_pkg::CMD_SELECT) begin
      sel_d = item_i.select_word[spim_pkg::SelectLines-1:0];
    end else if (item_i.cmd == spim_pkg::CMD_MODE) begin
      mode_d = item_i.mode_bits;
    end

    result_o.sclk      = sclk_d;
    result_o.mosi      = tx_d[7];
    result_o.select_n  = 32'(sel_d);
    result_o.rx_byte   = hold_d;
    result_o.ready_res = (phase_d == spim_pkg::PH_IDLE);
    result_o.mode_out  = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= spim_pkg::PH_IDLE;
      tick_q  <= '0;
      bit_q   <= 3'd0;
      tx_q    <= 8'd0;
      rx_q    <= 8'd0;
      hold_q  <= 8'd0;
      sel_q   <= '1;
      mode_q  <= 5'd0;
      sclk_q  <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      hold_q  <= hold_d;
      sel_q   <= sel_d;
      mode_q  <= mode_d;
      sclk_q  <= sclk_d;
    end
  end

  `ASSERT_NEVER(a_bits_only_busy, phase_q == spim_pkg::PH_IDLE && en_i &&
    item_i.cmd != spim_pkg::CMD_START && phase_d != spim_pkg::PH_IDLE)
  `ASSERT_PROP(a_start_clears_tick, en_i && phase_q == spim_pkg::PH_IDLE &&
    item_i.cmd == spim_pkg::CMD_START |=> tick_q == '0 && bit_q == 3'd0)
  `ASSERT_PROP(a_sclk_tracks, $past(en_i) |-> sclk_q == $past(sclk_d))

endmodule
`default_nettype wire
